// ===== src/fwips_pkg.sv =====
package fwips_pkg;

	localparam int WHEELS       = 4;
	localparam int COUNT_W      = 16;
	localparam int GAIN_W       = 12;
	localparam int TARGET_W     = 16;
	localparam int ERR_W        = 17;
	localparam int FRAC_BITS    = 8;
	localparam int ACC_W        = 22;
	localparam int PROD_W       = GAIN_W + 1 + ERR_W;
	localparam int SUM_W        = 32;
	localparam int DRIVE_W      = 14;
	localparam int COMPARE_W    = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_DATA_W    = WHEELS * COUNT_W;
	localparam int RES_W        = DRIVE_W + COMPARE_W + 1;
	localparam int OUT_DATA_W   = WHEELS * RES_W;

	localparam int OUTPUT_LIMIT     = 7199;
	localparam int ENCODER_MIDPOINT = 32768;

	localparam logic [GAIN_W-1:0]    PROP_GAIN_RST = GAIN_W'(1280);
	localparam logic [GAIN_W-1:0]    PREV_GAIN_RST = GAIN_W'(256);
	localparam logic signed [ERR_W:0] MIDPOINT     = (ERR_W+1)'(ENCODER_MIDPOINT);
	localparam logic signed [SUM_W-1:0] LIMIT_FX   = SUM_W'(OUTPUT_LIMIT << FRAC_BITS);
	localparam logic [COMPARE_W-1:0] LIMIT_CMP     = COMPARE_W'(OUTPUT_LIMIT);

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREV_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BL = 3'd5;

	typedef struct packed {
		logic [GAIN_W-1:0]                 prop_gain;
		logic [GAIN_W-1:0]                 prev_gain;
		logic [WHEELS-1:0][TARGET_W-1:0]   target;
	} cfg_t;

	typedef struct packed {
		logic                 reverse;
		logic [COMPARE_W-1:0] compare;
		logic [DRIVE_W-1:0]   drive;
	} lane_res_t;

endpackage

// ===== src/fwips_cfg.sv =====
module fwips_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [fwips_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [fwips_pkg::CFG_DATA_W-1:0]  wr_data,
	output fwips_pkg::cfg_t                   cfg
);
	import fwips_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= PROP_GAIN_RST;
			cfg_q.prev_gain <= PREV_GAIN_RST;
			cfg_q.target    <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PROP_GAIN: cfg_q.prop_gain <= wr_data[GAIN_W-1:0];
				REG_PREV_GAIN: cfg_q.prev_gain <= wr_data[GAIN_W-1:0];
				REG_TARGET_FR: cfg_q.target[0] <= wr_data[TARGET_W-1:0];
				REG_TARGET_FL: cfg_q.target[1] <= wr_data[TARGET_W-1:0];
				REG_TARGET_BR: cfg_q.target[2] <= wr_data[TARGET_W-1:0];
				REG_TARGET_BL: cfg_q.target[3] <= wr_data[TARGET_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/fwips_lane.sv =====
module fwips_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [fwips_pkg::COUNT_W-1:0]    count,
	input  logic [fwips_pkg::GAIN_W-1:0]     prop_gain,
	input  logic [fwips_pkg::GAIN_W-1:0]     prev_gain,
	input  logic [fwips_pkg::TARGET_W-1:0]   target,
	output fwips_pkg::lane_res_t             res
);
	import fwips_pkg::*;

	localparam int INT_W = ACC_W - FRAC_BITS;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ERR_W-1:0]  perr_q;

	logic signed [ERR_W:0]    speed;
	logic signed [ERR_W:0]    err_full;
	logic signed [ERR_W-1:0]  err;
	logic signed [PROD_W-1:0] prod_cur;
	logic signed [PROD_W-1:0] prod_prev;
	logic signed [SUM_W-1:0]  sum;
	logic signed [ACC_W-1:0]  acc_d;
	logic [ACC_W-1:0]         mag;
	logic [INT_W-1:0]         int_mag;
	logic [DRIVE_W-1:0]       drive;

	always_comb begin
		speed     = $signed({2'b00, count}) - MIDPOINT;
		err_full  = $signed({{(ERR_W+1-TARGET_W){target[TARGET_W-1]}}, target}) - speed;
		err       = err_full[ERR_W-1:0];
		prod_cur  = $signed({1'b0, prop_gain}) * err;
		prod_prev = $signed({1'b0, prev_gain}) * perr_q;
		sum       = SUM_W'(acc_q) + SUM_W'(prod_cur) - SUM_W'(prod_prev);

		if (sum > LIMIT_FX)
			acc_d = ACC_W'(LIMIT_FX);
		else if (sum < -LIMIT_FX)
			acc_d = ACC_W'(-LIMIT_FX);
		else
			acc_d = sum[ACC_W-1:0];

		// truncate toward zero: work on the magnitude
		mag     = acc_d[ACC_W-1] ? ACC_W'(-acc_d) : ACC_W'(acc_d);
		int_mag = mag[ACC_W-1:FRAC_BITS];
		drive   = acc_d[ACC_W-1] ? DRIVE_W'(-int_mag) : DRIVE_W'(int_mag);

		res.drive   = drive;
		res.reverse = drive[DRIVE_W-1];
		res.compare = drive[DRIVE_W-1] ? int_mag[COMPARE_W-1:0]
		                               : LIMIT_CMP - int_mag[COMPARE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			perr_q <= '0;
		end else if (en) begin
			acc_q  <= acc_d;
			perr_q <= err;
		end
	end

endmodule

// ===== src/four_wheel_incremental_pi_speed.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  s_axis_tdata: four 16-bit encoder counts
// m_axis    out  m_axis_tvalid/m_axis_tready  m_axis_tdata: drive, compare, reverse x4
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One item per cycle unless m_axis_tready stalls; input then result register.
// The four lanes each do three subtracts, two 13x17 multiplies, an add and a clamp
// in the single stage between those registers.
// Reset clears accumulators and previous errors and loads the register defaults.
// A stalled result holds in the result register; one more item waits in the input
// register, after which s_axis_tready drops.
module four_wheel_incremental_pi_speed (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// count_front_right, count_front_left, count_back_right, count_back_left
	input  logic [fwips_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// drive_fr/fl/br/bl (14b each), compare_fr/fl/br/bl (13b each),
	// reverse_fr/fl/br/bl (1b each)
	output logic [fwips_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fwips_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fwips_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fwips_pkg::*;

	localparam int CMP_BASE = WHEELS * DRIVE_W;
	localparam int REV_BASE = WHEELS * (DRIVE_W + COMPARE_W);

	cfg_t                           cfg;
	logic                           valid_s1;
	logic [WHEELS-1:0][COUNT_W-1:0] count_s1;
	logic                           out_valid_q;
	lane_res_t [WHEELS-1:0]         res_d;
	lane_res_t [WHEELS-1:0]         res_q;
	logic                           advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;

	fwips_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			count_s1 <= s_axis_tdata;
		if (advance)
			res_q <= res_d;
	end

	for (genvar w = 0; w < WHEELS; w++) begin : g_lane
		fwips_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.count     (count_s1[w]),
			.prop_gain (cfg.prop_gain),
			.prev_gain (cfg.prev_gain),
			.target    (cfg.target[w]),
			.res       (res_d[w])
		);

		assign m_axis_tdata[w*DRIVE_W +: DRIVE_W]              = res_q[w].drive;
		assign m_axis_tdata[CMP_BASE + w*COMPARE_W +: COMPARE_W] = res_q[w].compare;
		assign m_axis_tdata[REV_BASE + w]                      = res_q[w].reverse;
	end

endmodule
